// ----- sv/dpd_pkg.sv -----
// dpd_pkg: shared types and constants for the binary64 divider
// no dependencies
package dpd_pkg;

  localparam logic [10:0] EXP_ONES    = 11'h7FF;
  localparam logic [63:0] DEFAULT_NAN = 64'h7FF8000000000000;
  localparam int          QBITS       = 56;

  // classified item handed from front to back
  typedef struct packed {
    logic        special;   // result fully known, no division needed
    logic [63:0] result;    // special result
    logic        sign;
    logic [12:0] exp;       // signed biased exponent of quotient
    logic [52:0] ma;        // normalized dividend significand
    logic [52:0] mb;        // normalized divisor significand
  } dpd_item_t;

endpackage

// ----- sv/dpd_front.sv -----
// dpd_front: accepts operands, handles special cases, normalizes subnormals
// depends on dpd_pkg
module dpd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [63:0]         in_dividend_bits,
  input  logic [63:0]         in_divisor_bits,
  output logic                fr_valid,
  input  logic                fr_ready,
  output dpd_pkg::dpd_item_t  fr_item
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_NORM = 3'b010,
    S_OUT  = 3'b100
  } fstate_t;

  fstate_t            state_r, state_nxt;
  dpd_pkg::dpd_item_t item_r, item_nxt;

  logic        sa, sb, s;
  logic [10:0] ea, eb;
  logic [51:0] fa, fb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

  assign sa = in_dividend_bits[63];
  assign sb = in_divisor_bits[63];
  assign s  = sa ^ sb;
  assign ea = in_dividend_bits[62:52];
  assign eb = in_divisor_bits[62:52];
  assign fa = in_dividend_bits[51:0];
  assign fb = in_divisor_bits[51:0];
  assign a_nan  = (ea == dpd_pkg::EXP_ONES) && (fa != '0);
  assign b_nan  = (eb == dpd_pkg::EXP_ONES) && (fb != '0);
  assign a_inf  = (ea == dpd_pkg::EXP_ONES) && (fa == '0);
  assign b_inf  = (eb == dpd_pkg::EXP_ONES) && (fb == '0);
  assign a_zero = (ea == '0) && (fa == '0);
  assign b_zero = (eb == '0) && (fb == '0);

  assign in_ready = (state_r == S_IDLE);
  assign fr_valid = (state_r == S_OUT);
  assign fr_item  = item_r;

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt.special = 1'b1;
          item_nxt.sign    = s;
          item_nxt.result  = {s, 63'd0};
          item_nxt.ma      = {(ea != '0), fa};
          item_nxt.mb      = {(eb != '0), fb};
          // exponent: max(ea,1) - max(eb,1) + bias
          item_nxt.exp = 13'({2'b00, ((ea == '0) ? 11'd1 : ea)})
                       - 13'({2'b00, ((eb == '0) ? 11'd1 : eb)}) + 13'd1023;
          if (a_nan) begin
            item_nxt.result = in_dividend_bits;
          end else if (b_nan) begin
            item_nxt.result = in_divisor_bits;
          end else if (a_inf) begin
            item_nxt.result = b_inf ? dpd_pkg::DEFAULT_NAN
                                    : {s, dpd_pkg::EXP_ONES, 52'd0};
          end else if (b_inf) begin
            item_nxt.result = {s, 63'd0};
          end else if (b_zero) begin
            item_nxt.result = a_zero ? dpd_pkg::DEFAULT_NAN
                                     : {s, dpd_pkg::EXP_ONES, 52'd0};
          end else if (a_zero) begin
            item_nxt.result = {s, 63'd0};
          end else begin
            item_nxt.special = 1'b0;
          end
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        // one bit shift per cycle on each operand until leading one found
        if (!item_r.special && !item_r.ma[52]) begin
          item_nxt.ma  = {item_r.ma[51:0], 1'b0};
          item_nxt.exp = item_r.exp - 13'd1;
        end
        if (!item_r.special && !item_r.mb[52]) begin
          item_nxt.mb  = {item_r.mb[51:0], 1'b0};
          item_nxt.exp = item_nxt.exp + 13'd1;
        end
        if (item_r.special || (item_r.ma[52] && item_r.mb[52]))
          state_nxt = S_OUT;
      end
      S_OUT: begin
        if (fr_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
    item_r <= item_nxt;
  end

  a_norm_done: assert property (@(posedge clk) disable iff (!rst_n)
    (fr_valid && !fr_item.special) |-> (fr_item.ma[52] && fr_item.mb[52]))
    else $error("front released unnormalized operand");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (fr_valid && !fr_ready) |=> (fr_valid && $stable(fr_item)))
    else $error("front item changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("front ready while busy");

endmodule

// ----- sv/dpd_fifo.sv -----
// dpd_fifo: two-entry queue between front and back
// depends on dpd_pkg
module dpd_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  dpd_pkg::dpd_item_t wr_item,
  output logic               rd_valid,
  input  logic               rd_ready,
  output dpd_pkg::dpd_item_t rd_item
);

  dpd_pkg::dpd_item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
    if (wr_en) mem_r[wp_r] <= wr_item;
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    ((cnt_r == 2'd0) || (cnt_r == 2'd2)) |-> (wp_r == rp_r))
    else $error("queue pointers inconsistent");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !rd_en) |=> (cnt_r == 2'd2))
    else $error("full queue lost an entry");

endmodule

// ----- sv/dpd_back.sv -----
// dpd_back: radix-2 restoring divide, denormalize, then round and pack
// depends on dpd_pkg
module dpd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               bk_valid,
  output logic               bk_ready,
  input  dpd_pkg::dpd_item_t bk_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_quotient_bits
);

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_DIV   = 5'b00010,
    B_SHIFT = 5'b00100,
    B_ROUND = 5'b01000,
    B_OUT   = 5'b10000
  } bstate_t;

  bstate_t     state_r, state_nxt;
  logic        sign_r, sign_nxt;
  logic [12:0] exp_r, exp_nxt;
  logic [53:0] rem_r, rem_nxt;
  logic [52:0] mb_r, mb_nxt;
  logic [55:0] q_r, q_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] res_r, res_nxt;

  logic [54:0] diff;
  logic [53:0] rem_a;
  logic        qbit;
  logic [52:0] m, m_inc;
  logic [2:0]  grs;
  logic        up;

  assign diff  = {1'b0, rem_r} - {2'b00, mb_r};
  assign qbit  = !diff[54];
  assign rem_a = qbit ? diff[53:0] : rem_r;

  assign m     = q_r[55:3];
  assign grs   = q_r[2:0];
  assign up    = (grs > 3'd4) || (grs == 3'd4 && m[0]);
  assign m_inc = m + 53'(up);

  assign bk_ready          = (state_r == B_IDLE);
  assign out_valid         = (state_r == B_OUT);
  assign out_quotient_bits = res_r;

  always_comb begin
    state_nxt = state_r;
    sign_nxt  = sign_r;
    exp_nxt   = exp_r;
    rem_nxt   = rem_r;
    mb_nxt    = mb_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    unique case (state_r)
      B_IDLE: begin
        if (bk_valid) begin
          sign_nxt = bk_item.sign;
          res_nxt  = bk_item.result;
          mb_nxt   = bk_item.mb;
          q_nxt    = '0;
          cnt_nxt  = '0;
          if (bk_item.ma < bk_item.mb) begin
            rem_nxt = {bk_item.ma, 1'b0};
            exp_nxt = bk_item.exp - 13'd1;
          end else begin
            rem_nxt = {1'b0, bk_item.ma};
            exp_nxt = bk_item.exp;
          end
          state_nxt = bk_item.special ? B_OUT : B_DIV;
        end
      end
      B_DIV: begin
        q_nxt   = {q_r[54:0], qbit};
        rem_nxt = {rem_a[52:0], 1'b0};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(dpd_pkg::QBITS - 1)) begin
          q_nxt[0]  = qbit | (rem_a != '0);
          state_nxt = B_SHIFT;
        end
      end
      B_SHIFT: begin
        // denormalize one bit per cycle, keeping sticky
        // far below the subnormal range only the sticky bit survives
        if ($signed(exp_r) <= -13'sd56) begin
          q_nxt   = {55'd0, |q_r};
          exp_nxt = 13'd1;
        end else if ($signed(exp_r) <= 0 && q_r != '0) begin
          q_nxt   = {1'b0, q_r[55:2], q_r[1] | q_r[0]};
          exp_nxt = exp_r + 13'd1;
        end else begin
          state_nxt = B_ROUND;
        end
        if ($signed(exp_r) <= 0 && q_r == '0) state_nxt = B_ROUND;
      end
      B_ROUND: begin
        if ($signed(exp_r) >= 13'sd2047) begin
          res_nxt = {sign_r, dpd_pkg::EXP_ONES, 52'd0};
        end else if ($signed(exp_r) <= 0) begin
          // fully zero quotient
          res_nxt = {sign_r, 63'd0};
        end else if (!q_r[55]) begin
          // subnormal path; carry into bit 52 forms exponent 1
          res_nxt = {sign_r, 10'd0, m_inc};
        end else if (m_inc[52] == 1'b0 && m[52]) begin
          // rounding overflowed 2.0: mantissa 1.0
          if (exp_r + 13'd1 >= 13'd2047)
            res_nxt = {sign_r, dpd_pkg::EXP_ONES, 52'd0};
          else
            res_nxt = {sign_r, 11'(exp_r + 13'd1), 52'd0};
        end else begin
          res_nxt = {sign_r, exp_r[10:0], m_inc[51:0]};
        end
        state_nxt = B_OUT;
      end
      B_OUT: begin
        if (out_ready) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else        state_r <= state_nxt;
    sign_r <= sign_nxt;
    exp_r  <= exp_nxt;
    rem_r  <= rem_nxt;
    mb_r   <= mb_nxt;
    q_r    <= q_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
  end

  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (rem_r < {mb_r, 1'b0}))
    else $error("partial remainder out of range");
  a_lead: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV && cnt_r == 6'(dpd_pkg::QBITS - 1)) |=> q_r[55])
    else $error("quotient lost its leading one");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_quotient_bits)))
    else $error("result changed while stalled");

endmodule

// ----- sv/double_precision_divider.sv -----
// double_precision_divider: binary64 divide, round to nearest even
// depends on dpd_pkg, dpd_front, dpd_fifo, dpd_back
//
//  channel  signals                                   direction
//  in       in_valid/in_ready, in_dividend_bits,      input
//           in_divisor_bits
//  out      out_valid/out_ready, out_quotient_bits    output
//
// front: accept, then one-bit normalization steps
// back: load, 56 quotient bits (radix 2), denormalize, round
// typical normal operands: the divide loop dominates; the front can accept new operands while the back still divides
// special cases skip the divide and go straight from load to output in the back
// rst_n synchronous active low clears control only; either side stalls on its own
module double_precision_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_dividend_bits,
  input  logic [63:0] in_divisor_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_quotient_bits
);

  // front to queue
  logic               fr_valid, fr_ready;
  dpd_pkg::dpd_item_t fr_item;
  // queue to back
  logic               bk_valid, bk_ready;
  dpd_pkg::dpd_item_t bk_item;

  // classify and normalize
  dpd_front u_front (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_dividend_bits, .in_divisor_bits,
    .fr_valid, .fr_ready, .fr_item
  );

  // decoupling queue
  dpd_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(fr_valid), .wr_ready(fr_ready), .wr_item(fr_item),
    .rd_valid(bk_valid), .rd_ready(bk_ready), .rd_item(bk_item)
  );

  // divide, round, pack
  dpd_back u_back (
    .clk, .rst_n,
    .bk_valid, .bk_ready, .bk_item,
    .out_valid, .out_ready, .out_quotient_bits
  );

endmodule
